### sv/lkp2_pkg.sv
// Shared types, constants and mix-round function for the lookup2 hash block.
// No dependencies; imported by every module of the block.
package lkp2_pkg;

   localparam logic [31:0] GOLDEN_RATIO   = 32'h9e3779b9;
   localparam int          QUEUE_DEPTH    = 4;
   localparam logic [3:0]  LAST_BLOCK_POS = 4'd11;
   localparam logic [3:0]  LAST_ROUND     = 4'd8;

   typedef struct packed {
      logic        first;
      logic        blk;
      logic        fin;
      logic [31:0] seed;
      logic [31:0] word_a;
      logic [31:0] word_b;
      logic [31:0] word_c;
      logic [31:0] len;
   } cmd_type;

   typedef struct packed {
      logic    push;
      cmd_type cmd;
   } front_out_type;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
   } words_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_MIX,
      BK_LEN
   } back_state_type;

   function automatic logic [4:0] mix_shift(input logic [3:0] round);
      logic [4:0] sh;
      unique case (round)
         4'd0: sh = 5'd13;
         4'd1: sh = 5'd8;
         4'd2: sh = 5'd13;
         4'd3: sh = 5'd12;
         4'd4: sh = 5'd16;
         4'd5: sh = 5'd5;
         4'd6: sh = 5'd3;
         4'd7: sh = 5'd10;
         4'd8: sh = 5'd15;
         default: sh = 5'd0;
      endcase
      return sh;
   endfunction

   function automatic words_type mix_round(input words_type w, input logic [3:0] round);
      words_type  r;
      logic [4:0] sh;
      r  = w;
      sh = mix_shift(round);
      unique case (round)
         4'd0, 4'd3, 4'd6: r.a = (w.a - w.b - w.c) ^ (w.c >> sh);
         4'd1, 4'd4, 4'd7: r.b = (w.b - w.c - w.a) ^ (w.a << sh);
         4'd2, 4'd5, 4'd8: r.c = (w.c - w.a - w.b) ^ (w.b >> sh);
         default: r = w;
      endcase
      return r;
   endfunction

endpackage

### sv/lkp2_front.sv
// Front end: accepts key bytes, packs them into 12-byte block words and
// pushes block and finish commands into the queue. Depends on lkp2_pkg.
module lkp2_front import lkp2_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [7:0]    req_key_byte,
   input  logic          req_has_byte,
   input  logic          req_is_last,
   input  logic [31:0]   req_seed,
   input  logic          q_full,
   output front_out_type q_wr
);

   logic        open_ff,  open_in;
   logic        first_ff, first_in;
   logic [3:0]  pos_ff,   pos_in;
   logic [31:0] wa_ff,    wa_in;
   logic [31:0] wb_ff,    wb_in;
   logic [23:0] pend_ff,  pend_in;
   logic [31:0] total_ff, total_in;
   logic [31:0] seed_ff,  seed_in;

   logic        active;
   logic        cur_first;
   logic [3:0]  cur_pos;
   logic [31:0] cur_wa, cur_wb, cur_total, cur_seed;
   logic [23:0] cur_pend;
   logic [31:0] nwa, nwb, ntotal;
   logic [23:0] npend;
   logic        blk_done;
   logic [4:0]  sh;

   assign req_ready = !q_full;

   always_comb begin
      active    = req_valid && req_ready && (req_has_byte || req_is_last);
      cur_first = open_ff ? first_ff : 1'b1;
      cur_pos   = open_ff ? pos_ff   : 4'd0;
      cur_wa    = open_ff ? wa_ff    : 32'd0;
      cur_wb    = open_ff ? wb_ff    : 32'd0;
      cur_pend  = open_ff ? pend_ff  : 24'd0;
      cur_total = open_ff ? total_ff : 32'd0;
      cur_seed  = open_ff ? seed_ff  : req_seed;
      sh        = {cur_pos[1:0], 3'b000};
      nwa       = cur_wa;
      nwb       = cur_wb;
      npend     = cur_pend;
      blk_done  = 1'b0;
      if (req_has_byte) begin
         priority if (cur_pos < 4'd4) begin
            nwa = cur_wa | ({24'd0, req_key_byte} << sh);
         end else if (cur_pos < 4'd8) begin
            nwb = cur_wb | ({24'd0, req_key_byte} << sh);
         end else if (cur_pos < LAST_BLOCK_POS) begin
            npend = cur_pend | ({16'd0, req_key_byte} << sh);
         end else begin
            blk_done = 1'b1;
         end
      end
      ntotal = cur_total + {31'd0, req_has_byte};

      q_wr.push        = active && (blk_done || req_is_last);
      q_wr.cmd.first   = cur_first;
      q_wr.cmd.blk     = blk_done;
      q_wr.cmd.fin     = req_is_last;
      q_wr.cmd.seed    = cur_seed;
      q_wr.cmd.word_a  = nwa;
      q_wr.cmd.word_b  = nwb;
      q_wr.cmd.word_c  = blk_done ? {req_key_byte, cur_pend} : ({npend, 8'd0} + ntotal);
      q_wr.cmd.len     = ntotal;

      open_in  = open_ff;
      first_in = first_ff;
      pos_in   = pos_ff;
      wa_in    = wa_ff;
      wb_in    = wb_ff;
      pend_in  = pend_ff;
      total_in = total_ff;
      seed_in  = seed_ff;
      if (active) begin
         open_in  = !req_is_last;
         first_in = q_wr.push ? 1'b0 : cur_first;
         pos_in   = blk_done ? 4'd0  : cur_pos + {3'd0, req_has_byte};
         wa_in    = blk_done ? 32'd0 : nwa;
         wb_in    = blk_done ? 32'd0 : nwb;
         pend_in  = blk_done ? 24'd0 : npend;
         total_in = ntotal;
         seed_in  = cur_seed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 1'b0;
      end else begin
         open_ff <= open_in;
      end
      first_ff <= first_in;
      pos_ff   <= pos_in;
      wa_ff    <= wa_in;
      wb_ff    <= wb_in;
      pend_ff  <= pend_in;
      total_ff <= total_in;
      seed_ff  <= seed_in;
   end

endmodule

### sv/lkp2_fifo.sv
// Short command queue between the front end and the mix engine.
// Depends on lkp2_pkg for the command type.
module lkp2_fifo import lkp2_pkg::*; #(
   parameter int Depth = QUEUE_DEPTH
) (
   input  logic          clock,
   input  logic          reset,
   input  front_out_type in_wr,
   input  logic          pop,
   output logic          full,
   output logic          empty,
   output cmd_type       rd_cmd
);

   localparam int PtrW = $clog2(Depth);
   localparam int CntW = $clog2(Depth + 1);

   cmd_type           mem [Depth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff,  count_in;
   logic              do_push, do_pop;

   assign full   = (count_ff == CntW'(Depth));
   assign empty  = (count_ff == '0);
   assign rd_cmd = mem[rd_ptr_ff];

   always_comb begin
      do_push   = in_wr.push && !full;
      do_pop    = pop && !empty;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= in_wr.cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(in_wr.push && full))
      else $error("command pushed into a full queue");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(Depth))
      else $error("queue count above depth");

endmodule

### sv/lkp2_back.sv
// Mix engine (uses lkp2_pkg): takes block and finish commands, runs the 9-line
// mix one line per cycle; a key's last line stalls on a full hash register.
module lkp2_back import lkp2_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_empty,
   input  cmd_type     q_cmd,
   output logic        q_pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_hash_value
);

   back_state_type state_ff, state_in;
   logic [3:0]     round_ff, round_in;
   words_type      w_ff, w_in;
   logic           fin_ff, fin_in;
   logic           blk_ff, blk_in;
   logic [31:0]    len_ff, len_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [31:0]    rsp_hash_ff, rsp_hash_in;

   words_type      mixed;
   logic           rsp_free;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = rsp_hash_ff;

   always_comb begin
      mixed        = mix_round(w_ff, round_ff);
      rsp_free     = !rsp_valid_ff || rsp_ready;
      state_in     = state_ff;
      round_in     = round_ff;
      w_in         = w_ff;
      fin_in       = fin_ff;
      blk_in       = blk_ff;
      len_in       = len_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_hash_in  = rsp_hash_ff;
      q_pop        = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               w_in.a   = (q_cmd.first ? GOLDEN_RATIO : w_ff.a) + q_cmd.word_a;
               w_in.b   = (q_cmd.first ? GOLDEN_RATIO : w_ff.b) + q_cmd.word_b;
               w_in.c   = (q_cmd.first ? q_cmd.seed   : w_ff.c) + q_cmd.word_c;
               fin_in   = q_cmd.fin;
               blk_in   = q_cmd.blk;
               len_in   = q_cmd.len;
               round_in = 4'd0;
               state_in = BK_MIX;
            end
         end
         BK_MIX: begin
            if (round_ff != LAST_ROUND) begin
               w_in     = mixed;
               round_in = round_ff + 4'd1;
            end else if (blk_ff && fin_ff) begin
               w_in     = mixed;
               blk_in   = 1'b0;
               state_in = BK_LEN;
            end else if (fin_ff) begin
               if (rsp_free) begin
                  w_in         = mixed;
                  rsp_valid_in = 1'b1;
                  rsp_hash_in  = mixed.c;
                  state_in     = BK_IDLE;
               end
            end else begin
               w_in     = mixed;
               state_in = BK_IDLE;
            end
         end
         BK_LEN: begin
            w_in.c   = w_ff.c + len_ff;
            round_in = 4'd0;
            state_in = BK_MIX;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      round_ff    <= round_in;
      w_ff        <= w_in;
      fin_ff      <= fin_in;
      blk_ff      <= blk_in;
      len_ff      <= len_in;
      rsp_hash_ff <= rsp_hash_in;
   end

   a_len_then_mix: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_LEN |=> state_ff == BK_MIX && round_ff == 4'd0)
      else $error("length add not followed by a fresh mix");

   a_round_bounded: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_MIX |-> round_ff <= LAST_ROUND)
      else $error("mix round out of range");

   a_result_from_final: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == BK_MIX && $past(fin_ff)
                              && !$past(blk_ff))
      else $error("result raised outside a final mix");

endmodule

### sv/jenkins_lookup2_hash.sv
// Streaming lookup2 hash, one key byte per req_ transaction.
// Channels: req_ (key_byte, has_byte, is_last, seed) and rsp_ (hash_value),
// both valid/ready; a transaction moves when valid and ready are high.
// The first transaction of a key takes req_seed; a transaction with is_last
// closes the key and yields one rsp_ transaction; has_byte=0 with is_last=1
// gives the empty key (or closes an open key); has_byte=0, is_last=0 is dropped.
// Throughput: one byte per cycle while req_ready is high. The mix engine runs
// one mix line per cycle (a key's last line waits for a free result register)
// and mixes each 12-byte block once and each key end once, or twice when the
// key ends exactly on a block boundary; a stream of very short keys is thus
// limited by the engine. rsp_valid rises once the finish command has passed the
// queue, any block mix ahead, and the engine's idle, mix and any length-add states.
// The command queue holds QueueDepth entries; req_ready drops while it is full.
// A stalled receiver holds the result register; the engine waits on its last
// round, then the queue fills and req_ready drops.
// Reset (synchronous, active high) drops any open key and any pending result.
module jenkins_lookup2_hash import lkp2_pkg::*; #(
   parameter int QueueDepth = QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_key_byte,
   input  logic        req_has_byte,
   input  logic        req_is_last,
   input  logic [31:0] req_seed,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_hash_value
);

   front_out_type q_wr;
   cmd_type       q_cmd;
   logic          q_full, q_empty, q_pop;

   lkp2_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_key_byte (req_key_byte),
      .req_has_byte (req_has_byte),
      .req_is_last  (req_is_last),
      .req_seed     (req_seed),
      .q_full       (q_full),
      .q_wr         (q_wr)
   );

   lkp2_fifo #(
      .Depth (QueueDepth)
   ) u_fifo (
      .clock  (clock),
      .reset  (reset),
      .in_wr  (q_wr),
      .pop    (q_pop),
      .full   (q_full),
      .empty  (q_empty),
      .rd_cmd (q_cmd)
   );

   lkp2_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_cmd          (q_cmd),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hash_value (rsp_hash_value)
   );

endmodule
